>>> design/fprsc_pkg.sv
package fprsc_pkg;

    // frame buffer sizing
    localparam int MAX_DATA = 64;
    localparam int ADDR_W   = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int LEN_W    = 7;
    localparam int POS_W    = $clog2(MAX_DATA + 5);

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    // request kinds
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_VERDICT = 1'b1;

    // handler verdicts
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_NOK    = 2'd1;
    localparam logic [1:0] VERDICT_WAIT   = 2'd2;
    localparam logic [1:0] VERDICT_IGNORE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NACK = 2'd2;

    // frame positions; anything from POS_DATA up is data or end byte
    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SEQ  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_data;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic start_deliver;
        logic last_byte;
    } t_stat;

endpackage

>>> design/fprsc_if.sv
interface fprsc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [1:0] handler_verdict;

    modport source (output valid, output req_type, output rx_byte,
                    output handler_verdict, input ready);
    modport sink   (input valid, input req_type, input rx_byte,
                    input handler_verdict, output ready);
endinterface

interface fprsc_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                out_kind;
    logic [7:0]                seq_number;
    logic [7:0]                packet_type;
    logic [fprsc_pkg::LEN_W-1:0] data_length;
    logic [7:0]                data_byte;
    logic                      data_present;
    logic                      last_item;

    modport source (output valid, output out_kind, output seq_number,
                    output packet_type, output data_length, output data_byte,
                    output data_present, output last_item, input ready);
    modport sink   (input valid, input out_kind, input seq_number,
                    input packet_type, input data_length, input data_byte,
                    input data_present, input last_item, output ready);
endinterface

>>> design/fprsc_ctrl.sv
module fprsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fprsc_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output fprsc_pkg::t_cmd  o_cmd
);

    fprsc_pkg::t_state r_state;
    fprsc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fprsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.load_data = 1'b0;
        case (r_state)
            fprsc_pkg::ST_IDLE: begin
                // take a request only when the output slot can hold a reply
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
                if (o_cmd.accept && i_stat.start_deliver) begin
                    n_state = fprsc_pkg::ST_READ;
                end
            end
            fprsc_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = fprsc_pkg::ST_LOAD;
            end
            fprsc_pkg::ST_LOAD: begin
                // hold the read byte until the output slot frees up
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    n_state = i_stat.last_byte ? fprsc_pkg::ST_IDLE
                                               : fprsc_pkg::ST_READ;
                end
            end
            default: begin
                n_state = fprsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/fprsc_dp.sv
module fprsc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [7:0]                  i_cfg_data,
    input  logic                        i_req_type,
    input  logic [7:0]                  i_rx_byte,
    input  logic [1:0]                  i_handler_verdict,
    input  fprsc_pkg::t_cmd             i_cmd,
    input  logic                        i_out_ready,
    output fprsc_pkg::t_stat            o_stat,
    output logic                        o_out_valid,
    output logic [1:0]                  o_out_kind,
    output logic [7:0]                  o_seq_number,
    output logic [7:0]                  o_packet_type,
    output logic [fprsc_pkg::LEN_W-1:0] o_data_length,
    output logic [7:0]                  o_data_byte,
    output logic                        o_data_present,
    output logic                        o_last_item
);

    logic [7:0]                   r_start_byte;
    logic [7:0]                   r_end_byte;
    logic [fprsc_pkg::POS_W-1:0]  r_pos;
    logic [7:0]                   r_seq;
    logic [7:0]                   r_type;
    logic [fprsc_pkg::LEN_W-1:0]  r_len;
    logic                         r_await;
    logic [fprsc_pkg::ADDR_W-1:0] r_idx;
    logic [7:0]                   r_rd_data;
    logic [7:0]                   r_mem [fprsc_pkg::MAX_DATA];

    logic                         r_out_valid;
    logic [1:0]                   r_out_kind;
    logic [7:0]                   r_out_seq;
    logic [7:0]                   r_out_type;
    logic [fprsc_pkg::LEN_W-1:0]  r_out_len;
    logic [7:0]                   r_out_byte;
    logic                         r_out_present;
    logic                         r_out_last;

    logic [fprsc_pkg::POS_W-1:0]  w_data_idx;
    logic                         w_at_end;
    logic                         w_byte_req;
    logic                         w_end_ok;
    logic                         w_oversize;
    logic                         w_out_set;

    // decode of the current byte against the frame position
    assign w_data_idx = r_pos - fprsc_pkg::POS_DATA;
    assign w_at_end   = (w_data_idx >= fprsc_pkg::POS_W'(r_len));
    assign w_byte_req = (i_req_type == fprsc_pkg::REQ_BYTE) && !r_await;
    assign w_end_ok   = (i_rx_byte == r_end_byte);
    assign w_oversize = (i_rx_byte > 8'(fprsc_pkg::MAX_DATA));

    assign o_stat.out_free      = !r_out_valid || i_out_ready;
    assign o_stat.start_deliver = w_byte_req && (r_pos >= fprsc_pkg::POS_DATA) &&
                                  w_at_end && w_end_ok &&
                                  (r_len != fprsc_pkg::LEN_W'(0));
    assign o_stat.last_byte     = ((fprsc_pkg::LEN_W'(r_idx) + fprsc_pkg::LEN_W'(1))
                                   == r_len);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'd2;
            r_end_byte   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fprsc_pkg::CFG_START: r_start_byte <= i_cfg_data;
                fprsc_pkg::CFG_END:   r_end_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame buffer: write data bytes, registered read for delivery
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_byte_req && (r_pos >= fprsc_pkg::POS_DATA) && !w_at_end) begin
            r_mem[w_data_idx[fprsc_pkg::ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // frame parser and sequence tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= fprsc_pkg::POS_HUNT;
            r_seq   <= 8'd0;
            r_type  <= 8'd0;
            r_len   <= '0;
            r_await <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_req_type == fprsc_pkg::REQ_VERDICT) begin
                if (r_await && (i_handler_verdict != fprsc_pkg::VERDICT_WAIT)) begin
                    r_await <= 1'b0;
                    if (i_handler_verdict != fprsc_pkg::VERDICT_IGNORE) begin
                        r_seq  <= r_seq + 8'd1;
                        r_type <= 8'd0;
                        r_len  <= '0;
                    end
                end
            end else if (!r_await) begin
                case (r_pos)
                    fprsc_pkg::POS_HUNT: begin
                        if (i_rx_byte == r_start_byte) begin
                            r_pos <= fprsc_pkg::POS_SEQ;
                        end
                    end
                    fprsc_pkg::POS_SEQ: begin
                        r_pos <= (i_rx_byte == r_seq) ? fprsc_pkg::POS_TYPE
                                                      : fprsc_pkg::POS_HUNT;
                    end
                    fprsc_pkg::POS_TYPE: begin
                        r_type <= i_rx_byte;
                        r_pos  <= fprsc_pkg::POS_LEN;
                    end
                    fprsc_pkg::POS_LEN: begin
                        r_len <= i_rx_byte[fprsc_pkg::LEN_W-1:0];
                        r_pos <= w_oversize ? fprsc_pkg::POS_HUNT : fprsc_pkg::POS_DATA;
                    end
                    default: begin
                        if (w_at_end) begin
                            r_pos <= fprsc_pkg::POS_HUNT;
                            if (w_end_ok) begin
                                r_await <= 1'b1;
                            end
                        end else begin
                            r_pos <= r_pos + fprsc_pkg::POS_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // delivery index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.load_data) begin
            r_idx <= r_idx + fprsc_pkg::ADDR_W'(1);
        end
    end

    // decide whether a new result enters the output slot
    always_comb begin
        w_out_set = 1'b0;
        if (i_cmd.load_data) begin
            w_out_set = 1'b1;
        end else if (i_cmd.accept) begin
            if (i_req_type == fprsc_pkg::REQ_VERDICT) begin
                if (r_await && ((i_handler_verdict == fprsc_pkg::VERDICT_OK) ||
                                (i_handler_verdict == fprsc_pkg::VERDICT_NOK))) begin
                    w_out_set = 1'b1;
                end
            end else if (!r_await) begin
                case (r_pos)
                    fprsc_pkg::POS_HUNT, fprsc_pkg::POS_TYPE: ;
                    fprsc_pkg::POS_SEQ: begin
                        if (i_rx_byte != r_seq) begin
                            w_out_set = 1'b1;
                        end
                    end
                    fprsc_pkg::POS_LEN: begin
                        if (w_oversize) begin
                            w_out_set = 1'b1;
                        end
                    end
                    default: begin
                        if (w_at_end && (!w_end_ok || (r_len == fprsc_pkg::LEN_W'(0)))) begin
                            w_out_set = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // output slot valid: fill on a new result, drain on ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_set) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output slot payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_out_kind    <= fprsc_pkg::KIND_DATA;
            r_out_seq     <= 8'd0;
            r_out_type    <= r_type;
            r_out_len     <= r_len;
            r_out_byte    <= r_rd_data;
            r_out_present <= 1'b1;
            r_out_last    <= o_stat.last_byte;
        end else if (i_cmd.accept) begin
            if ((i_req_type == fprsc_pkg::REQ_BYTE) && (r_pos >= fprsc_pkg::POS_DATA) &&
                w_end_ok) begin
                // empty frame: one delivery with no data byte
                r_out_kind    <= fprsc_pkg::KIND_DATA;
                r_out_seq     <= 8'd0;
                r_out_type    <= r_type;
                r_out_len     <= r_len;
                r_out_byte    <= 8'd0;
                r_out_present <= 1'b0;
            end else begin
                // ack or nack carrying the expected sequence number
                r_out_kind    <= ((i_req_type == fprsc_pkg::REQ_VERDICT) &&
                                  (i_handler_verdict == fprsc_pkg::VERDICT_OK))
                                 ? fprsc_pkg::KIND_ACK : fprsc_pkg::KIND_NACK;
                r_out_seq     <= r_seq;
                r_out_type    <= 8'd0;
                r_out_len     <= '0;
                r_out_byte    <= 8'd0;
                r_out_present <= 1'b0;
            end
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_seq_number   = r_out_seq;
    assign o_packet_type  = r_out_type;
    assign o_data_length  = r_out_len;
    assign o_data_byte    = r_out_byte;
    assign o_data_present = r_out_present;
    assign o_last_item    = r_out_last;

endmodule

>>> design/framed_packet_receiver_seq_check.sv
// Channel   Dir   Handshake            Payload
// i_in      in    valid/ready          req_type, rx_byte, handler_verdict
// o_out     out   valid/ready          out_kind, seq_number, packet_type,
//                                      data_length, data_byte, data_present,
//                                      last_item
// i_cfg_*   in    write enable only    register index, 8-bit data
//
// A byte or verdict request is taken in the idle state whenever the output slot is
// free or being drained; an ack, nack or empty-frame result appears the next cycle.
// A frame of L data bytes streams out byte by byte (buffer read, then load of the
// output slot once it is free); no request is taken until the last byte is loaded.
// A stalled output holds the slot and blocks further requests.
// Reset is synchronous; the frame buffer is not cleared and needs no sweep.
module framed_packet_receiver_seq_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fprsc_in_if.sink          i_in,
    fprsc_out_if.source       o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    fprsc_pkg::t_cmd  w_cmd;
    fprsc_pkg::t_stat w_stat;

    fprsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    fprsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_in.req_type),
        .i_rx_byte         (i_in.rx_byte),
        .i_handler_verdict (i_in.handler_verdict),
        .i_cmd             (w_cmd),
        .i_out_ready       (o_out.ready),
        .o_stat            (w_stat),
        .o_out_valid       (o_out.valid),
        .o_out_kind        (o_out.out_kind),
        .o_seq_number      (o_out.seq_number),
        .o_packet_type     (o_out.packet_type),
        .o_data_length     (o_out.data_length),
        .o_data_byte       (o_out.data_byte),
        .o_data_present    (o_out.data_present),
        .o_last_item       (o_out.last_item)
    );

endmodule
